// ===== src/bsa_pkg.sv =====
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned BitIdxW = 6;
  localparam int unsigned CountW = 11;
  localparam int unsigned SlotW = 10;
  localparam logic [CountW-1:0] ResetCount = 11'd1024;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_CHECK = 2'd2,
    OP_ALLOC = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic scan_next;
    logic finish;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic scan_stop;
    logic clr_last;
  } sts_t;

endpackage

// ===== src/bsa_datapath.sv =====
// Datapath of the bitmap slot allocator: used-bit memory, word scan and result registers.
module bsa_datapath
  import bsa_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        in_op_i,
  input  logic [SlotW-1:0]  in_slot_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output logic [CountW-1:0] res_slot_o,
  output logic              res_in_use_o,
  output logic [1:0]        res_status_o
);

  localparam int unsigned NumWords = (CAPACITY + WordBits - 1) / WordBits;
  localparam int unsigned AddrW = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic [WordBits-1:0] mem [NumWords];

  logic [CountW-1:0]   count_q;
  logic [AddrW-1:0]    clr_ptr_q;
  logic [AddrW-1:0]    rd_ptr_q;
  logic [AddrW-1:0]    raddr_q;
  logic [WordBits-1:0] rdata_q;
  op_e                 op_q;
  logic [SlotW-1:0]    slot_q;
  logic [CountW-1:0]   res_slot_q;
  logic                res_in_use_q;
  logic [1:0]          res_status_q;

  logic [CountW-1:0]   live;
  logic [CountW-1:0]   limit;
  logic [WordBits-1:0] mask;
  logic [WordBits-1:0] free_bits;
  logic                hit;
  logic                last;
  logic [BitIdxW-1:0]  hit_bit;
  logic [BitIdxW-1:0]  bit_sel;
  logic                range_err;
  logic                re;
  logic [AddrW-1:0]    rd_addr;
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [WordBits-1:0] wdata;
  logic [CountW-1:0]   res_slot_d;
  logic                res_in_use_d;
  logic [1:0]          res_status_d;

  always_comb begin
    if (32'(count_q) > CAPACITY) begin
      live = CountW'(CAPACITY);
    end else begin
      live = count_q;
    end
  end

  assign limit = {live[CountW-1:3], 3'b000};

  always_comb begin
    if (32'(raddr_q) < 32'(limit[CountW-1:BitIdxW])) begin
      mask = '1;
    end else if (32'(raddr_q) == 32'(limit[CountW-1:BitIdxW])) begin
      mask = (64'd1 << limit[BitIdxW-1:0]) - 64'd1;
    end else begin
      mask = '0;
    end
  end

  assign free_bits = ~rdata_q & mask;
  assign hit = |free_bits;
  assign last = ((32'(raddr_q) + 32'd1) << BitIdxW) >= 32'(limit);

  always_comb begin
    hit_bit = '0;
    for (int i = int'(WordBits) - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = BitIdxW'(i);
      end
    end
  end

  assign bit_sel = slot_q[BitIdxW-1:0];
  assign range_err = {1'b0, slot_q} >= live;

  assign re = cmd_i.load | cmd_i.scan_next;

  always_comb begin
    if (cmd_i.load) begin
      if (in_op_i == OP_ALLOC) begin
        rd_addr = '0;
      end else begin
        rd_addr = AddrW'(in_slot_i >> BitIdxW);
      end
    end else begin
      rd_addr = rd_ptr_q;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = raddr_q;
    wdata = rdata_q;
    if (cmd_i.clr_step) begin
      we = 1'b1;
      waddr = clr_ptr_q;
      wdata = '0;
    end else if (cmd_i.finish) begin
      case (op_q)
        OP_ALLOC: begin
          we = hit;
          wdata = rdata_q | (64'd1 << hit_bit);
        end
        OP_SET: begin
          we = ~range_err;
          wdata = rdata_q | (64'd1 << bit_sel);
        end
        OP_CLEAR: begin
          we = ~range_err;
          wdata = rdata_q & ~(64'd1 << bit_sel);
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res_slot_d = '0;
    res_in_use_d = 1'b0;
    res_status_d = ST_OK;
    if (op_q == OP_ALLOC) begin
      if (hit) begin
        res_slot_d = CountW'((32'(raddr_q) << BitIdxW) + 32'(hit_bit));
      end else begin
        res_slot_d = live;
        res_status_d = ST_FULL;
      end
    end else if (range_err) begin
      res_status_d = ST_RANGE;
    end else if (op_q == OP_CHECK) begin
      res_in_use_d = rdata_q[bit_sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ResetCount;
      clr_ptr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
        clr_ptr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_ptr_q <= clr_ptr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(in_op_i);
      slot_q <= in_slot_i;
      rd_ptr_q <= AddrW'(1);
    end else if (cmd_i.scan_next) begin
      rd_ptr_q <= rd_ptr_q + AddrW'(1);
    end
    if (cmd_i.finish) begin
      res_slot_q <= res_slot_d;
      res_in_use_q <= res_in_use_d;
      res_status_q <= res_status_d;
    end
  end

  assign sts_o.is_alloc = (in_op_i == OP_ALLOC);
  assign sts_o.scan_stop = hit | last;
  assign sts_o.clr_last = (clr_ptr_q == AddrW'(NumWords - 1));

  assign res_slot_o = res_slot_q;
  assign res_in_use_o = res_in_use_q;
  assign res_status_o = res_status_q;

endmodule

// ===== src/bsa_ctrl.sv =====
// Controller of the bitmap slot allocator: request sequencing, clearing pass and result valid.
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic cfg_we_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) & ~cfg_we_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_ready_o & in_valid_i;
    cmd_o.clr_step = (state_q == S_CLEAR);
    cmd_o.scan_next = (state_q == S_SCAN) & ~sts_i.scan_stop;
    cmd_o.finish = out_free & ((state_q == S_RMW) | ((state_q == S_SCAN) & sts_i.scan_stop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_o.load) begin
            state_q <= sts_i.is_alloc ? S_SCAN : S_RMW;
          end
        end
        S_RMW: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cfg_we_i) begin
        state_q <= S_CLEAR;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator.
// The block keeps one used bit per slot in a memory of 64-bit words and serves one
// request at a time. Set, clear and check first read the word holding the slot, then
// post the result once the output register is free; set and clear of an in-range slot
// also write the updated word back. Alloc reads one word per cycle from word 0 and stops
// at the first word with a free slot below the allocation limit or at the last word under
// the limit, then posts the result once the output register is free. After reset and
// after every write of the slot count a clearing pass zeroes the memory one word a cycle,
// during which no request is accepted. A result waits in an output register, and the
// next request is taken meanwhile.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: slot[9:0].
  input  logic [15:0] s_axis_tdata,
  // Fields from bit 0: operation[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: alloc_slot[10:0], in_use[11], status[13:12].
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  cmd_t              cmd;
  sts_t              sts;
  logic [CountW-1:0] res_slot;
  logic              res_in_use;
  logic [1:0]        res_status;

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsa_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser),
    .in_slot_i    (s_axis_tdata[SlotW-1:0]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_slot_o   (res_slot),
    .res_in_use_o (res_in_use),
    .res_status_o (res_status)
  );

  assign m_axis_tdata = {2'b00, res_status, res_in_use, res_slot};

endmodule

// ===== src/bsa_checker.sv =====
// Port-level assertions for the bitmap slot allocator and their bind to the top level.
module bsa_checker
  import bsa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_we_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("request accepted during the clearing pass");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:12] == ST_OK || m_axis_tdata[13:12] == ST_RANGE
                      || m_axis_tdata[13:12] == ST_FULL)
    else $error("undefined status code");

  a_in_use_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[13:12] == ST_OK)
    else $error("in_use set on a rejected request");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we_i      (cfg_we_i)
);
